[src/smpq_pkg.sv]
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and constants for the stable minimum-first priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

  // Number of slots in the queue
  localparam int QUEUE_DEPTH = 16;
  // Width of the internal entry counter (holds 0..QUEUE_DEPTH)
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  // Width of the reported entry count
  localparam int ECNT_W      = 5;
  localparam int DATA_W      = 32;
  localparam int PRIO_W      = 32;

  // Operation codes carried in the input item
  localparam logic [1:0] MODE_ENQ = 2'd0;
  localparam logic [1:0] MODE_DEQ = 2'd1;
  localparam logic [1:0] MODE_CLR = 2'd2;

  // Decoded operation issued by the controller to the datapath
  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUSH,
    OP_POP,
    OP_CLEAR,
    OP_DROP
  } op_t;

  // Output register state
  typedef enum logic {
    OUT_EMPTY,
    OUT_FULL
  } out_state_t;

  typedef struct packed {
    logic exec;
    op_t  op;
  } smpq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } smpq_status_t;

endpackage

[src/smpq_ctrl.sv]
// ----------------------------------------------------------------------------
// smpq_ctrl
// Handshake controller: decodes the transaction mode and tracks the result.
// ----------------------------------------------------------------------------
module smpq_ctrl
  import smpq_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   mode,
  output logic         out_valid,
  input  logic         out_ready,
  input  smpq_status_t status,
  output smpq_cmd_t    cmd
);

  out_state_t state, state_next;
  logic       in_fire;
  logic       out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= OUT_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      OUT_EMPTY: begin
        if (in_fire) state_next = OUT_FULL;
      end
      OUT_FULL: begin
        if (in_fire) begin
          state_next = OUT_FULL;
        end else if (out_fire) begin
          state_next = OUT_EMPTY;
        end
      end
      default: state_next = OUT_EMPTY;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      OUT_EMPTY: begin
        in_ready = 1'b1;
      end
      OUT_FULL: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
      end
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase

    cmd.exec = in_valid && in_ready;
    case (mode)
      MODE_ENQ: cmd.op = status.full ? OP_DROP : OP_PUSH;
      MODE_DEQ: cmd.op = status.empty ? OP_NOP : OP_POP;
      MODE_CLR: cmd.op = OP_CLEAR;
      default:  cmd.op = OP_NOP;
    endcase
  end

endmodule

[src/smpq_datapath.sv]
// ----------------------------------------------------------------------------
// smpq_datapath
// Sorted slot array with parallel compare and shift, count and drop flag.
// ----------------------------------------------------------------------------
module smpq_datapath
  import smpq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  smpq_cmd_t                cmd,
  input  logic signed [DATA_W-1:0] item_data,
  input  logic signed [PRIO_W-1:0] item_priority,
  output smpq_status_t             status,
  output logic                     head_valid,
  output logic signed [DATA_W-1:0] head_data,
  output logic signed [PRIO_W-1:0] head_priority,
  output logic [ECNT_W-1:0]        entry_count,
  output logic                     overflow
);

  logic signed [DATA_W-1:0] slot_data     [QUEUE_DEPTH];
  logic signed [PRIO_W-1:0] slot_priority [QUEUE_DEPTH];
  logic [CNT_W-1:0]         count, count_next;
  logic                     dropped;
  logic [QUEUE_DEPTH-1:0]   stay;  // slot is occupied and stays ahead of the new entry
  logic                     shift_en;

  assign shift_en = cmd.exec && ((cmd.op == OP_PUSH) || (cmd.op == OP_POP));

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] d_next;
      logic signed [PRIO_W-1:0] p_next;
      logic                     take_new;

      assign stay[i] = (CNT_W'(i) < count) && (slot_priority[i] <= item_priority);

      if (i == 0) begin : g_first
        assign take_new = 1'b1;
      end else begin : g_rest
        assign take_new = stay[i-1];
      end

      always_comb begin
        d_next = slot_data[i];
        p_next = slot_priority[i];
        if (cmd.op == OP_PUSH) begin
          if (stay[i]) begin
            d_next = slot_data[i];
            p_next = slot_priority[i];
          end else if (take_new) begin
            d_next = item_data;
            p_next = item_priority;
          end else begin
            d_next = slot_data[(i == 0) ? 0 : i - 1];
            p_next = slot_priority[(i == 0) ? 0 : i - 1];
          end
        end else if (cmd.op == OP_POP) begin
          d_next = slot_data[(i == QUEUE_DEPTH - 1) ? i : i + 1];
          p_next = slot_priority[(i == QUEUE_DEPTH - 1) ? i : i + 1];
        end
      end

      always_ff @(posedge clk) begin
        if (shift_en) begin
          slot_data[i]     <= d_next;
          slot_priority[i] <= p_next;
        end
      end
    end
  endgenerate

  always_comb begin
    count_next = count;
    case (cmd.op)
      OP_PUSH:  count_next = count + CNT_W'(1);
      OP_POP:   count_next = count - CNT_W'(1);
      OP_CLEAR: count_next = '0;
      default:  count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.exec) begin
      count   <= count_next;
      dropped <= (cmd.op == OP_DROP);
    end
  end

  assign status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  assign head_valid    = !status.empty;
  assign head_data     = head_valid ? slot_data[0] : '0;
  assign head_priority = head_valid ? slot_priority[0] : '0;
  assign entry_count   = ECNT_W'(count);
  assign overflow      = dropped;

endmodule

[src/stable_min_priority_queue.sv]
// ----------------------------------------------------------------------------
// stable_min_priority_queue
// Bounded minimum-first priority queue, stable among equal priorities.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction: mode selects
//   enqueue, dequeue of the head, or clear. item_data and item_priority are
//   used by enqueue only. Any other mode is a no-op that still reports.
//   Output channel (out_valid/out_ready) returns one transaction per input:
//   the head entry after the operation (data and priority 0 when empty),
//   the entry count, and overflow for an enqueue dropped on a full queue.
//   Latency: the result is shown the cycle after the input is accepted.
//   Throughput: one transaction per cycle while out_ready is high; all slots
//   compare against the new priority in parallel and shift by one place at
//   once, and the output register is refilled in the same cycle it is taken.
//   When the receiver stalls, the result holds and in_ready follows
//   out_ready, so at most one result is ever waiting.
//   Reset empties the queue and drops any waiting result; slot contents are
//   not cleared, since only occupied slots are ever read.
// ----------------------------------------------------------------------------
module stable_min_priority_queue
  import smpq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               mode,
  input  logic signed [DATA_W-1:0] item_data,
  input  logic signed [PRIO_W-1:0] item_priority,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     head_valid,
  output logic signed [DATA_W-1:0] head_data,
  output logic signed [PRIO_W-1:0] head_priority,
  output logic [ECNT_W-1:0]        entry_count,
  output logic                     overflow
);

  smpq_cmd_t    cmd;
  smpq_status_t status;

  // Controller: handshake and operation decode
  smpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: sorted slots; result fields come straight from its registers,
  // which only change when a new transaction is accepted
  smpq_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .item_data     (item_data),
    .item_priority (item_priority),
    .status        (status),
    .head_valid    (head_valid),
    .head_data     (head_data),
    .head_priority (head_priority),
    .entry_count   (entry_count),
    .overflow      (overflow)
  );

endmodule

[src/smpq_checker.sv]
// ----------------------------------------------------------------------------
// smpq_checker
// Port-level checks for the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module smpq_checker
  import smpq_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [1:0]               mode,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     head_valid,
  input logic signed [DATA_W-1:0] head_data,
  input logic signed [PRIO_W-1:0] head_priority,
  input logic [ECNT_W-1:0]        entry_count,
  input logic                     overflow
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Report zero fields for an empty queue
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !head_valid |-> head_data == '0 && head_priority == '0)
    else $error("empty queue reports nonzero head");

  // Drop an enqueue only when full
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> head_valid && entry_count == ECNT_W'(QUEUE_DEPTH))
    else $error("overflow on a queue that is not full");

  // Empty the queue on clear
  a_clear: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && mode == MODE_CLR |=>
      out_valid && !head_valid && entry_count == '0 && !overflow)
    else $error("clear did not empty the queue");

endmodule

bind stable_min_priority_queue smpq_checker u_smpq_checker (.*);
